// File: sv/projected_screen_bounds_core_assert.svh
// Assertion macros used by the checker file.
`ifndef PROJECTED_SCREEN_BOUNDS_CORE_ASSERT_SVH
`define PROJECTED_SCREEN_BOUNDS_CORE_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define PSB_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PSB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: sv/psb_pkg.sv
// Package with shared types and constants of the screen bounds block.
package psb_pkg;
  localparam int FRAC = 16;
  localparam int NDC_W = 18;
  localparam int PIX_W = 15;
  localparam logic signed [NDC_W-1:0] ONE = NDC_W'(1 << FRAC);
  localparam logic signed [NDC_W-1:0] MONE = -ONE;

  localparam logic [3:0] REG_XF = 4'd0;
  localparam logic [3:0] REG_XS = 4'd1;
  localparam logic [3:0] REG_YF = 4'd2;
  localparam logic [3:0] REG_YS = 4'd3;
  localparam logic [3:0] REG_WF = 4'd4;
  localparam logic [3:0] REG_WS = 4'd5;
  localparam logic [3:0] REG_VW = 4'd6;
  localparam logic [3:0] REG_VH = 4'd7;

  typedef struct packed {
    logic load;      // capture input vertex, clear accumulator
    logic mac;       // one multiply-accumulate step
    logic [1:0] row; // 0 x, 1 y, 2 w
    logic [1:0] term;
    logic save_row;  // store accumulator into row register
    logic div_start;
    logic div_y;     // numerator: 0 x, 1 y
    logic div_step;
    logic upd_x;
    logic upd_y;
    logic fin;       // compute clamped bounds
    logic pix_step;  // one screen product
    logic [1:0] pix_idx;
    logic out_load;
    logic reset_bounds;
  } cmd_t;

  typedef struct packed {
    logic w_pos;
    logic div_done;
    logic sel;
    logic last;
  } sts_t;
endpackage

// File: sv/psb_if.sv
// Valid/ready channel interfaces for the vertex and result transactions.
interface psb_in_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic vertex_selected;
  logic final_vertex;
  modport source (output valid, pos_x, pos_y, pos_z, vertex_selected, final_vertex,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vertex_selected, final_vertex,
                output ready);
endinterface

interface psb_out_if (input logic clk);
  logic valid;
  logic ready;
  logic bounds_valid;
  logic signed [17:0] ndc_left;
  logic signed [17:0] ndc_right;
  logic signed [17:0] ndc_top;
  logic signed [17:0] ndc_bottom;
  logic [14:0] screen_x1;
  logic [14:0] screen_y1;
  logic [14:0] screen_x2;
  logic [14:0] screen_y2;
  modport source (output valid, bounds_valid, ndc_left, ndc_right, ndc_top, ndc_bottom,
                  screen_x1, screen_y1, screen_x2, screen_y2, input ready);
  modport sink (input valid, bounds_valid, ndc_left, ndc_right, ndc_top, ndc_bottom,
                screen_x1, screen_y1, screen_x2, screen_y2, output ready);
endinterface

// File: sv/projected_screen_bounds_core.sv
// Top level of the projected screen bounds block.
// Each vertex transaction is taken in the idle state; a selected vertex then runs its
// multiply-accumulate steps, four terms per row (w row first, then x and y), through
// one 32x32 multiplier, with a test of w after the w row, and two serial divisions in
// a single shared divider; a vertex that is unselected or has w not positive skips to
// the bounds step. A final vertex adds the screen coordinate products and a load of
// the result register; the result transaction stays in that register until it is
// taken, and the next vertex is accepted once it has been loaded. Configuration
// registers are written over the APB port at byte address 8*i and read back the same way.
module projected_screen_bounds_core (
  input  logic clk,
  input  logic rst,
  psb_in_if.sink in_ch,
  psb_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [5:0] paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic pready
);
  logic [63:0] rows [6];
  logic [14:0] view_width, view_height;
  logic [3:0] idx;
  psb_pkg::cmd_t cmd;
  psb_pkg::sts_t sts;

  assign pready = 1'b1;
  assign idx = {1'b0, paddr[5:3]};

  // Register file; the low three address bits are ignored, so every address maps to a register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) rows[i] <= '0;
      view_width <= '0;
      view_height <= '0;
    end else if (psel && penable && pwrite) begin
      if (idx < psb_pkg::REG_VW) rows[idx[2:0]] <= pwdata;
      else if (idx == psb_pkg::REG_VW) view_width <= pwdata[14:0];
      else view_height <= pwdata[14:0];
    end
  end

  always_comb begin
    if (idx < psb_pkg::REG_VW) prdata = rows[idx[2:0]];
    else if (idx == psb_pkg::REG_VW) prdata = 64'(view_width);
    else prdata = 64'(view_height);
  end

  psb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_busy(out_ch.valid && !out_ch.ready), .sts(sts), .cmd(cmd)
  );

  logic rv;
  logic signed [17:0] rl, rr, rt, rb;
  logic [14:0] x1, y1, x2, y2;

  psb_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .pos_x(in_ch.pos_x), .pos_y(in_ch.pos_y), .pos_z(in_ch.pos_z),
    .vertex_selected(in_ch.vertex_selected), .final_vertex(in_ch.final_vertex),
    .rows(rows), .view_width(view_width), .view_height(view_height),
    .r_valid(rv), .r_left(rl), .r_right(rr), .r_top(rt), .r_bottom(rb),
    .r_x1(x1), .r_y1(y1), .r_x2(x2), .r_y2(y2)
  );

  // Output register holds the result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (cmd.out_load) out_ch.valid <= 1'b1;
    else if (out_ch.ready) out_ch.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch.bounds_valid <= rv;
      out_ch.ndc_left <= rl;
      out_ch.ndc_right <= rr;
      out_ch.ndc_top <= rt;
      out_ch.ndc_bottom <= rb;
      out_ch.screen_x1 <= x1;
      out_ch.screen_y1 <= y1;
      out_ch.screen_x2 <= x2;
      out_ch.screen_y2 <= y2;
    end
  end
endmodule

// File: sv/psb_ctrl.sv
// Sequencer that steps the datapath through one vertex transaction.
module psb_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_busy,
  input  psb_pkg::sts_t sts,
  output psb_pkg::cmd_t cmd
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_MAC = 7'b0000010, S_WCHK = 7'b0000100,
    S_DIV = 7'b0001000, S_FIN = 7'b0010000, S_PIX = 7'b0100000,
    S_OUT = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [3:0] cnt, cnt_next;
  logic divy, divy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      divy <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      divy <= divy_next;
    end
  end

  // No transaction is taken while reset is held.
  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    divy_next = divy;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cnt_next = '0;
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        // w row first (row 2), then x, then y; four terms each.
        if (!sts.sel) begin
          state_next = S_FIN;
        end else begin
          cmd.mac = 1'b1;
          cmd.row = (cnt[3:2] == 2'd0) ? 2'd2 : (cnt[3:2] == 2'd1 ? 2'd0 : 2'd1);
          cmd.term = cnt[1:0];
          cmd.save_row = (cnt[1:0] == 2'd3);
          cnt_next = cnt + 4'd1;
          if (cnt == 4'd3) state_next = S_WCHK;
          else if (cnt == 4'd11) begin
            cmd.div_start = 1'b1;
            divy_next = 1'b0;
            state_next = S_DIV;
          end
        end
      end
      S_WCHK: begin
        if (sts.w_pos) state_next = S_MAC;
        else state_next = S_FIN;
      end
      S_DIV: begin
        cmd.div_y = divy;
        if (sts.div_done) begin
          if (divy) begin
            cmd.upd_y = 1'b1;
            state_next = S_FIN;
          end else begin
            cmd.upd_x = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_y = 1'b1;
            divy_next = 1'b1;
          end
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FIN: begin
        if (!sts.last) state_next = S_IDLE;
        else begin
          cmd.fin = 1'b1;
          cnt_next = '0;
          state_next = S_PIX;
        end
      end
      S_PIX: begin
        cmd.pix_step = 1'b1;
        cmd.pix_idx = cnt[1:0];
        cnt_next = cnt + 4'd1;
        if (cnt[1:0] == 2'd3) state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          cmd.reset_bounds = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// File: sv/psb_dp.sv
// Datapath: projection rows, serial divider, bounds and pixel products.
module psb_dp (
  input  logic clk,
  input  logic rst,
  input  psb_pkg::cmd_t cmd,
  output psb_pkg::sts_t sts,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic vertex_selected,
  input  logic final_vertex,
  input  logic [63:0] rows [6],
  input  logic [14:0] view_width,
  input  logic [14:0] view_height,
  output logic r_valid,
  output logic signed [17:0] r_left,
  output logic signed [17:0] r_right,
  output logic signed [17:0] r_top,
  output logic signed [17:0] r_bottom,
  output logic [14:0] r_x1,
  output logic [14:0] r_y1,
  output logic [14:0] r_x2,
  output logic [14:0] r_y2
);
  localparam int F = psb_pkg::FRAC;
  logic signed [31:0] px, py, pz;
  logic sel, last;
  logic [63:0] acc, xr, yr, wr;
  logic signed [17:0] bl, br, bt, bb;

  // Multiply-accumulate: one term per cycle in the MAC state, paused for the w test.
  logic [63:0] rf, rs;
  logic signed [31:0] coef, coord;
  logic signed [63:0] prod, term;
  always_comb begin
    rf = rows[{1'b0, cmd.row} * 3'd2];
    rs = rows[{1'b0, cmd.row} * 3'd2 + 3'd1];
    unique case (cmd.term)
      2'd0: begin coef = rf[31:0]; coord = px; end
      2'd1: begin coef = rf[63:32]; coord = py; end
      2'd2: begin coef = rs[31:0]; coord = pz; end
      default: begin coef = rs[63:32]; coord = 32'sd16384; end
    endcase
    prod = coef * coord;
    term = (cmd.term == 2'd3) ? prod : (prod >>> 2);
  end
  logic [63:0] acc_sum;
  assign acc_sum = acc + 64'(term);

  // Serial divider, one quotient bit per cycle.
  logic [63:0] num, mag, rem, rem_sh;
  logic [F:0] q;
  logic [4:0] dcnt;
  logic neg, dsat;
  logic signed [17:0] qv;
  assign num = cmd.div_y ? yr : xr;
  assign mag = num[63] ? (64'd0 - num) : num;
  assign rem_sh = {rem[62:0], 1'b0};
  assign qv = neg ? -$signed(18'(q)) : $signed(18'(q));

  // Pixel products.
  logic signed [17:0] cl, cr, ct, cb, span;
  logic [14:0] size;
  logic [33:0] pprod;
  always_comb begin
    unique case (cmd.pix_idx)
      2'd0: begin size = view_width; span = cl + psb_pkg::ONE; end
      2'd1: begin size = view_height; span = psb_pkg::ONE - ct; end
      2'd2: begin size = view_width; span = cr + psb_pkg::ONE; end
      default: begin size = view_height; span = psb_pkg::ONE - cb; end
    endcase
    pprod = 34'(size) * 34'(span[F+1:0]);
  end
  logic [14:0] pix;
  assign pix = pprod[F+1+14:F+1];
  logic [14:0] p [4];

  assign sts.w_pos = !wr[63] && (wr != 64'd0);
  assign sts.div_done = (dcnt == 5'(F)) || dsat;
  assign sts.sel = sel;
  assign sts.last = last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px <= pos_x; py <= pos_y; pz <= pos_z;
      sel <= vertex_selected; last <= final_vertex;
      acc <= '0;
    end
    if (cmd.mac) begin
      if (cmd.save_row) begin
        acc <= '0;
        unique case (cmd.row)
          2'd0: xr <= acc_sum;
          2'd1: yr <= acc_sum;
          default: wr <= acc_sum;
        endcase
      end else begin
        acc <= acc_sum;
      end
    end
    if (cmd.div_start) begin
      neg <= num[63];
      rem <= mag;
      q <= (mag >= wr) ? (F+1)'(1 << F) : '0;
      dsat <= (mag >= wr);
      dcnt <= '0;
    end else if (cmd.div_step) begin
      dcnt <= dcnt + 5'd1;
      if (rem_sh >= wr) begin
        rem <= rem_sh - wr;
        q <= {q[F-1:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q <= {q[F-1:0], 1'b0};
      end
    end
    if (cmd.fin) begin
      cl <= (bl < psb_pkg::MONE) ? psb_pkg::MONE : bl;
      cr <= (br > psb_pkg::ONE) ? psb_pkg::ONE : br;
      ct <= (bt > psb_pkg::ONE) ? psb_pkg::ONE : bt;
      cb <= (bb < psb_pkg::MONE) ? psb_pkg::MONE : bb;
    end
    if (cmd.pix_step) p[cmd.pix_idx] <= pix;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reset_bounds) begin
      bl <= psb_pkg::ONE; br <= psb_pkg::MONE;
      bt <= psb_pkg::MONE; bb <= psb_pkg::ONE;
    end else begin
      if (cmd.upd_x) begin
        if (qv < bl) bl <= qv;
        if (qv > br) br <= qv;
      end
      if (cmd.upd_y) begin
        if (qv > bt) bt <= qv;
        if (qv < bb) bb <= qv;
      end
    end
  end

  assign r_valid = (cl < cr) && (ct > cb);
  assign r_left = cl;
  assign r_right = cr;
  assign r_top = ct;
  assign r_bottom = cb;
  assign r_x1 = r_valid ? p[0] : '0;
  assign r_y1 = r_valid ? p[1] : '0;
  assign r_x2 = r_valid ? p[2] : '0;
  assign r_y2 = r_valid ? p[3] : '0;
endmodule

// File: sv/psb_checker.sv
// Port-level checker for the projected screen bounds block, with its bind.
`include "projected_screen_bounds_core_assert.svh"
module psb_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic bounds_valid,
  input logic signed [17:0] ndc_left,
  input logic signed [17:0] ndc_right,
  input logic [14:0] screen_x1
);
  `PSB_ASSERT_NEXT(a_in_busy, clk, rst, in_valid && in_ready, !in_ready)
  `PSB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `PSB_ASSERT_IMPL(a_valid_order, clk, rst, out_valid && bounds_valid, ndc_left < ndc_right)
  `PSB_ASSERT_IMPL(a_pix_zero, clk, rst, out_valid && !bounds_valid, screen_x1 == 15'd0)
endmodule

bind projected_screen_bounds_core psb_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .bounds_valid(out_ch.bounds_valid), .ndc_left(out_ch.ndc_left),
  .ndc_right(out_ch.ndc_right), .screen_x1(out_ch.screen_x1)
);

// File: dv/psb_tb_if.sv
// Package with the result record type used by the testbench.
`timescale 1ns / 1ps
package psb_tb_pkg;
  typedef struct packed {
    logic bounds_valid;
    logic signed [17:0] ndc_left;
    logic signed [17:0] ndc_right;
    logic signed [17:0] ndc_top;
    logic signed [17:0] ndc_bottom;
    logic [14:0] screen_x1;
    logic [14:0] screen_y1;
    logic [14:0] screen_x2;
    logic [14:0] screen_y2;
  } bounds_rec_t;
endpackage

// File: dv/projected_screen_bounds_core_tb.sv
// Self-checking testbench for the projected screen bounds block.
`timescale 1ns / 1ps
module projected_screen_bounds_core_tb;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  psb_in_if in_ch (clk);
  psb_out_if out_ch (clk);

  projected_screen_bounds_core uut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: a private copy of the projection rows, viewport and bounds.
  logic [63:0] proj_rows [6];
  logic [14:0] vp_width;
  logic [14:0] vp_height;
  logic signed [31:0] lo_x, hi_x, hi_y, lo_y;

  psb_tb_pkg::bounds_rec_t expected_bounds [$];
  int mismatches = 0;
  longint unsigned cycles = 0;
  // The sink stalls at random while this is set; the long hold-off keeps ready low.
  bit sink_idle_en = 1'b1;
  bit src_idle_en = 1'b1;
  bit hold_sink = 1'b0;

  function automatic logic signed [63:0] mul_q30(logic [31:0] coef, logic [31:0] coord);
    logic signed [63:0] prod;
    prod = $signed(coef) * $signed(coord);
    return prod >>> 2;
  endfunction

  // One projection row in Q34.30.
  function automatic logic signed [63:0] project_row(int idx, logic [31:0] px,
                                                      logic [31:0] py, logic [31:0] pz);
    logic [63:0] f, s;
    logic signed [63:0] k;
    f = proj_rows[2*idx];
    s = proj_rows[2*idx+1];
    k = $signed(s[63:32]);
    return mul_q30(f[31:0], px) + mul_q30(f[63:32], py) + mul_q30(s[31:0], pz) + (k <<< 14);
  endfunction

  // Quotient num/w in Q1.16, toward zero, saturated to one.
  function automatic logic signed [31:0] ndc_quotient(logic signed [63:0] num,
                                                       logic [63:0] w);
    logic [63:0] mag, rem;
    logic [31:0] q;
    mag = num[63] ? 64'(-num) : num;
    if (mag >= w) q = 32'(1 << psb_pkg::FRAC);
    else begin
      rem = mag;
      q = 0;
      for (int i = 0; i < psb_pkg::FRAC; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= w) begin
          rem = rem - w;
          q[0] = 1'b1;
        end
      end
    end
    return num[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [14:0] pixel_of(logic [14:0] size, logic signed [31:0] span);
    logic [63:0] p;
    p = 64'(size) * 64'(unsigned'(span));
    return 15'(p / (64'd2 << psb_pkg::FRAC));
  endfunction

  task automatic reset_bounds();
    lo_x = 1 << psb_pkg::FRAC;
    hi_x = -(1 << psb_pkg::FRAC);
    hi_y = -(1 << psb_pkg::FRAC);
    lo_y = 1 << psb_pkg::FRAC;
  endtask

  // Folds one accepted vertex into the bounds and queues a result on the final vertex.
  task automatic predict_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                bit sel, bit fin);
    logic signed [63:0] w;
    logic signed [31:0] vx, vy, l, r, t, b;
    psb_tb_pkg::bounds_rec_t rec;
    if (sel) begin
      w = project_row(2, px, py, pz);
      if (w > 0) begin
        vx = ndc_quotient(project_row(0, px, py, pz), w);
        vy = ndc_quotient(project_row(1, px, py, pz), w);
        if (vx < lo_x) lo_x = vx;
        if (vx > hi_x) hi_x = vx;
        if (vy > hi_y) hi_y = vy;
        if (vy < lo_y) lo_y = vy;
      end
    end
    if (fin) begin
      l = lo_x;
      r = hi_x;
      t = hi_y;
      b = lo_y;
      rec = '0;
      rec.bounds_valid = (l < r) && (t > b);
      rec.ndc_left = 18'(l);
      rec.ndc_right = 18'(r);
      rec.ndc_top = 18'(t);
      rec.ndc_bottom = 18'(b);
      if (rec.bounds_valid) begin
        rec.screen_x1 = pixel_of(vp_width, l + (1 << psb_pkg::FRAC));
        rec.screen_y1 = pixel_of(vp_height, (1 << psb_pkg::FRAC) - t);
        rec.screen_x2 = pixel_of(vp_width, r + (1 << psb_pkg::FRAC));
        rec.screen_y2 = pixel_of(vp_height, (1 << psb_pkg::FRAC) - b);
      end
      expected_bounds.push_back(rec);
      reset_bounds();
    end
  endtask

  // APB write: setup then access phase. pready is always high.
  task automatic write_reg(logic [3:0] idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(idx) << 3;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      psb_pkg::REG_VW: vp_width = val[14:0];
      psb_pkg::REG_VH: vp_height = val[14:0];
      default: proj_rows[idx[2:0]] = val;
    endcase
  endtask

  // Sends one vertex transaction, with an optional random idle burst before it.
  // Valid stays high after acceptance until the next call or drain() changes it.
  task automatic send_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             bit sel, bit fin);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    in_ch.pos_z <= pz;
    in_ch.vertex_selected <= sel;
    in_ch.final_vertex <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_vertex(px, py, pz, sel, fin);
  endtask

  // Stops offering vertices, waits until every result has arrived, then lets the
  // block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_bounds.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Well-behaved camera: x and y pass through, w = z, with an optional random x offset.
  task automatic load_camera(bit jitter);
    write_reg(psb_pkg::REG_XF, {32'h0, 32'h0001_0000});
    write_reg(psb_pkg::REG_XS, {jitter ? 32'($urandom_range(0, 'h8000)) : 32'h0, 32'h0});
    write_reg(psb_pkg::REG_YF, {32'h0001_0000, 32'h0});
    write_reg(psb_pkg::REG_YS, 64'h0);
    write_reg(psb_pkg::REG_WF, 64'h0);
    write_reg(psb_pkg::REG_WS, {32'h0, 32'h0001_0000});
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(0, 'h40000)) - 'h20000);
    endcase
  endfunction

  task automatic test_directed();
    write_reg(psb_pkg::REG_VW, 64'd16384);
    write_reg(psb_pkg::REG_VH, 64'd16383);
    load_camera(1'b0);
    // An empty mesh gives the reset bounds and an invalid result.
    send_vertex(0, 0, 0, 1'b0, 1'b1);
    // Vertices in front of the camera; the last one is not selected.
    send_vertex(32'hFFFF_8000, 32'h0000_4000, 32'h0001_0000, 1'b1, 1'b0);
    send_vertex(32'h0000_8000, 32'hFFFF_C000, 32'h0001_0000, 1'b1, 1'b0);
    send_vertex(32'h0003_0000, 32'h0000_0000, 32'h0001_0000, 1'b0, 1'b1);
    // Saturation from coordinates far outside the frustum.
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 1'b0);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b1, 1'b1);
    // Behind the camera and on the camera plane: both skipped.
    send_vertex(32'h0000_1000, 32'h0000_1000, 32'hFFFF_0000, 1'b1, 1'b0);
    send_vertex(32'h0000_1000, 32'h0000_1000, 32'h0000_0000, 1'b1, 1'b1);
    // A single point gives zero-area, invalid bounds.
    send_vertex(32'h0000_2000, 32'h0000_3000, 32'h0001_0000, 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(psb_pkg::REG_VW, 64'd0);
    write_reg(psb_pkg::REG_VH, 64'h7FFF);
    write_reg(psb_pkg::REG_XF, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(psb_pkg::REG_XS, 64'h8000_0000_7FFF_FFFF);
    write_reg(psb_pkg::REG_YF, 64'h7FFF_FFFF_8000_0000);
    write_reg(psb_pkg::REG_YS, 64'hFFFF_FFFF_0000_0000);
    write_reg(psb_pkg::REG_WF, 64'h0000_0001_0000_0001);
    write_reg(psb_pkg::REG_WS, 64'h7FFF_FFFF_7FFF_FFFF);
    for (int i = 0; i < 12; i++)
      send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'b1, i % 4 == 3);
    drain();
  endtask

  task automatic test_random_meshes(int n_items, bit camera);
    int sent;
    int mesh_len;
    sent = 0;
    while (sent < n_items) begin
      mesh_len = $urandom_range(0, 6);
      for (int i = 0; i <= mesh_len; i++) begin
        if (camera)
          send_vertex(32'($signed($urandom_range(0, 'h60000)) - 'h30000),
                      32'($signed($urandom_range(0, 'h60000)) - 'h30000),
                      32'($signed($urandom_range(0, 'h30000)) - 'h8000),
                      $urandom_range(0, 7) != 0, i == mesh_len);
        else
          send_vertex(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 1),
                      i == mesh_len);
        sent++;
      end
    end
    drain();
  endtask

  // The sink holds off long enough for the block to stall its input.
  task automatic test_backpressure();
    hold_sink = 1'b1;
    for (int i = 0; i < 8; i++)
      send_vertex(32'h0000_1000 * i, 32'hFFFF_F000, 32'h0001_0000, 1'b1, 1'b1);
    drain();
  endtask

  // Output checker: each result is compared with the oldest expectation.
  always @(posedge clk) begin
    psb_tb_pkg::bounds_rec_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = {out_ch.bounds_valid, out_ch.ndc_left, out_ch.ndc_right, out_ch.ndc_top,
             out_ch.ndc_bottom, out_ch.screen_x1, out_ch.screen_y1, out_ch.screen_x2,
             out_ch.screen_y2};
      if (expected_bounds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", got);
      end else begin
        want = expected_bounds.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // Result sink: random stall bursts, plus one long hold-off counted here.
  initial begin
    int hold;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        out_ch.ready <= 1'b0;
        hold = 0;
        while (hold < 600) begin
          @(posedge clk);
          hold++;
        end
        hold_sink = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 9)) @(posedge clk);
      end else
        out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.pos_x <= '0;
    in_ch.pos_y <= '0;
    in_ch.pos_z <= '0;
    in_ch.vertex_selected <= 1'b0;
    in_ch.final_vertex <= 1'b0;
    foreach (proj_rows[i]) proj_rows[i] = '0;
    vp_width = '0;
    vp_height = '0;
    reset_bounds();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_register_extremes();
    write_reg(psb_pkg::REG_VW, 64'd1920);
    write_reg(psb_pkg::REG_VH, 64'd1080);
    load_camera(1'b1);
    test_random_meshes(300, 1'b1);
    test_backpressure();
    write_reg(psb_pkg::REG_VW, 64'($urandom_range(0, 16384)));
    write_reg(psb_pkg::REG_WF,
              {32'($urandom_range(0, 'h2000)), 32'($urandom_range(0, 'h2000))});
    test_random_meshes(120, 1'b0);
    // Closing stretch with no idling on either side.
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    test_random_meshes(150, 1'b1);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

// File: projected_screen_bounds_core.f
+incdir+sv
sv/psb_pkg.sv
sv/psb_if.sv
sv/psb_ctrl.sv
sv/psb_dp.sv
sv/projected_screen_bounds_core.sv
sv/psb_checker.sv
dv/psb_tb_if.sv
dv/projected_screen_bounds_core_tb.sv
